// ----- rtl/core/cse_pkg.sv -----
// Shared types, constants and the saturation helper for the Chebyshev series evaluator.
// Used by cse_map, cse_step, chebyshev_series_eval and cse_checker; depends on nothing.
package cse_pkg;

  localparam int DEGREE    = 5;
  localparam int FRAC_BITS = 16;
  localparam int NUM_COEFS = 6;
  localparam int DATA_W    = 32;
  localparam int SCALE_W   = 31;
  localparam int INDEX_W   = 4;

  localparam logic signed [63:0] Q_ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_RANGE_LOW   = 4'd0;
  localparam logic [INDEX_W-1:0] REG_RANGE_SCALE = 4'd1;
  localparam logic [INDEX_W-1:0] REG_COEF_FIRST  = 4'd2;
  localparam logic [INDEX_W-1:0] REG_COEF_LAST   = 4'd7;

  // State carried from one recurrence step to the next.
  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] t_prev;
    logic signed [DATA_W-1:0] t_cur;
    logic signed [DATA_W-1:0] sum;
    logic                     sat;
  } step_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clipped;
  } clip_t;

  // Clips a wide signed value to the 32-bit range and reports whether it clipped.
  function automatic clip_t clip32(input logic signed [63:0] v);
    clip_t r;
    if (v > S32_MAX) begin
      r.value   = S32_MAX[DATA_W-1:0];
      r.clipped = 1'b1;
    end else if (v < S32_MIN) begin
      r.value   = S32_MIN[DATA_W-1:0];
      r.clipped = 1'b1;
    end else begin
      r.value   = v[DATA_W-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cse_map.sv -----
// Three-stage mapping of a sample onto the Chebyshev interval: u = (x - low) * scale - 1.
// Depends on cse_pkg.
module cse_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cse_pkg::DATA_W-1:0] sample,
  input  logic signed [cse_pkg::DATA_W-1:0] range_low,
  input  logic [cse_pkg::SCALE_W-1:0]       range_scale,
  input  logic signed [cse_pkg::DATA_W-1:0] coef_0,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cse_pkg::step_t                    out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic signed [cse_pkg::DATA_W:0] diff;
  logic signed [63:0]              prod;
  logic signed [63:0]              u_wide;
  cse_pkg::clip_t                  u_clip;
  cse_pkg::step_t                  res;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // The arithmetic shift of the product is a floor division by 2^FRAC_BITS.
  assign u_wide = (prod >>> cse_pkg::FRAC_BITS) - cse_pkg::Q_ONE;
  assign u_clip = cse_pkg::clip32(u_wide);

  always_ff @(posedge clk) begin
    if (en1) begin
      diff <= {sample[cse_pkg::DATA_W-1], sample} - {range_low[cse_pkg::DATA_W-1], range_low};
    end
    if (en2) begin
      prod <= diff * $signed({1'b0, range_scale});
    end
    if (en3) begin
      res.u      <= u_clip.value;
      res.t_prev <= cse_pkg::Q_ONE[cse_pkg::DATA_W-1:0];
      res.t_cur  <= u_clip.value;
      res.sum    <= coef_0;
      res.sat    <= u_clip.clipped;
    end
  end

  assign out_valid = v3;
  assign out_data  = res;

endmodule

// ----- rtl/core/cse_step.sv -----
// One two-stage step of the Chebyshev recurrence: adds c_k*T_k and forms T_(k+1).
// Depends on cse_pkg.
module cse_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cse_pkg::step_t                    in_data,
  input  logic signed [cse_pkg::DATA_W-1:0] coef,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cse_pkg::step_t                    out_data
);

  logic v1, v2;
  logic en1, en2;
  logic signed [cse_pkg::DATA_W-1:0] u_in, t_cur_in;
  logic signed [63:0]                prod_c, prod_u;
  logic signed [cse_pkg::DATA_W-1:0] u_a, t_prev_a, t_cur_a, sum_a;
  logic                              sat_a;
  logic signed [63:0]                sum_wide, t_next_wide;
  logic signed [cse_pkg::DATA_W-1:0] sum_ext, t_prev_ext;
  cse_pkg::clip_t                    sum_clip, t_clip;
  cse_pkg::step_t                    res;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  assign u_in     = in_data.u;
  assign t_cur_in = in_data.t_cur;

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_c   <= coef * t_cur_in;
      prod_u   <= u_in * t_cur_in;
      u_a      <= in_data.u;
      t_prev_a <= in_data.t_prev;
      t_cur_a  <= in_data.t_cur;
      sum_a    <= in_data.sum;
      sat_a    <= in_data.sat;
    end
  end

  assign sum_ext     = sum_a;
  assign t_prev_ext  = t_prev_a;
  assign sum_wide    = 64'(sum_ext) + (prod_c >>> cse_pkg::FRAC_BITS);
  // Shifting by one bit less doubles the product, giving 2*u*T_k.
  assign t_next_wide = (prod_u >>> (cse_pkg::FRAC_BITS - 1)) - 64'(t_prev_ext);
  assign sum_clip    = cse_pkg::clip32(sum_wide);
  assign t_clip      = cse_pkg::clip32(t_next_wide);

  always_ff @(posedge clk) begin
    if (en2) begin
      res.u      <= u_a;
      res.t_prev <= t_cur_a;
      res.t_cur  <= t_clip.value;
      res.sum    <= sum_clip.value;
      // The next polynomial from the final step is unused, so its clip is not flagged.
      res.sat    <= sat_a | sum_clip.clipped | (t_clip.clipped & !last);
    end
  end

  assign out_valid = v2;
  assign out_data  = res;

endmodule

// ----- rtl/core/chebyshev_series_eval.sv -----
// Top level of the Chebyshev series evaluator: configuration registers and the pipeline.
// Depends on cse_pkg, cse_map and cse_step.
//
// Usage:
// Samples (signed Q16.16) enter on sample/sample_valid and are accepted at a rising
// edge where sample_valid is high and sample_stall is low. Each sample yields exactly
// one result item on approx_value/saturated, offered with result_valid and taken at an
// edge where result_stall is low. The datapath is 13 register stages deep: three stages
// map the sample to u = (sample - range_low) * range_scale - 1, then two stages per
// series term (a multiply stage, then a shift, add and clip stage) for terms 1..DEGREE.
// Throughput is one item per cycle unless the receiver stalls; each stage holds one
// item and hands it on whenever the stage after it has room.
// Configuration is written on cfg_valid/cfg_index/cfg_data; cfg_ready is always high
// and a write takes effect at the next edge. Write only while the pipeline is empty.
// Indexes 0..7 select range_low, range_scale and coef_0..coef_5; others are ignored.
// Reset empties every stage and loads range_low = -1.0, range_scale = 1.0 and zero
// coefficients. While the receiver stalls, the result holds and empty stages behind it
// keep filling; sample_stall rises only when every stage holds an item.
module chebyshev_series_eval (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [cse_pkg::DATA_W-1:0]  sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [cse_pkg::DATA_W-1:0]  approx_value,
  output logic                               saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cse_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [cse_pkg::DATA_W-1:0]         cfg_data
);

  logic signed [cse_pkg::DATA_W-1:0] range_low;
  logic [cse_pkg::SCALE_W-1:0]       range_scale;
  logic signed [cse_pkg::DATA_W-1:0] coef [cse_pkg::NUM_COEFS];

  // Link k carries the item after term k has been added (link 0 leaves the mapper).
  cse_pkg::step_t link_data  [cse_pkg::DEGREE+1];
  logic           link_valid [cse_pkg::DEGREE+1];
  logic           link_ready [cse_pkg::DEGREE+1];
  logic           map_ready;

  assign cfg_ready = 1'b1;

  // Register writes. Coefficient k sits at index REG_COEF_FIRST + k.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= -32'sd65536;
      range_scale <= 31'd65536;
      for (int i = 0; i < cse_pkg::NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cse_pkg::REG_RANGE_LOW) begin
        range_low <= cfg_data;
      end else if (cfg_index == cse_pkg::REG_RANGE_SCALE) begin
        range_scale <= cfg_data[cse_pkg::SCALE_W-1:0];
      end else if (cfg_index >= cse_pkg::REG_COEF_FIRST &&
                   cfg_index <= cse_pkg::REG_COEF_LAST) begin
        coef[3'(cfg_index - cse_pkg::REG_COEF_FIRST)] <= cfg_data;
      end
    end
  end

  cse_map u_map (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample_valid),
    .in_ready    (map_ready),
    .sample      (sample),
    .range_low   (range_low),
    .range_scale (range_scale),
    .coef_0      (coef[0]),
    .out_valid   (link_valid[0]),
    .out_ready   (link_ready[0]),
    .out_data    (link_data[0])
  );

  assign sample_stall = !map_ready;

  // One recurrence step per series term; coefficients above DEGREE are never read.
  for (genvar k = 1; k <= cse_pkg::DEGREE; k++) begin : g_term
    cse_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k-1]),
      .in_ready  (link_ready[k-1]),
      .in_data   (link_data[k-1]),
      .coef      (coef[k]),
      .last      (k == cse_pkg::DEGREE),
      .out_valid (link_valid[k]),
      .out_ready (link_ready[k]),
      .out_data  (link_data[k])
    );
  end

  assign link_ready[cse_pkg::DEGREE] = !result_stall;
  assign result_valid = link_valid[cse_pkg::DEGREE];
  assign approx_value = link_data[cse_pkg::DEGREE].sum;
  assign saturated    = link_data[cse_pkg::DEGREE].sat;

endmodule

// ----- rtl/core/cse_checker.sv -----
// Port-level assertions for chebyshev_series_eval, bound to the top level below.
// Depends on cse_pkg.
module cse_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic signed [cse_pkg::DATA_W-1:0] approx_value,
  input logic                              saturated
);

  // A stalled result item stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(approx_value) && $stable(saturated))
    else $error("result payload changed while stalled");

  // With the output stage empty, the pipeline always has room for a sample.
  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("sample stalled with an empty output stage");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered right after reset");

endmodule

bind chebyshev_series_eval cse_checker u_cse_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .approx_value (approx_value),
  .saturated    (saturated)
);

// ----- test/chebyshev_series_eval_test.sv -----
// Self-checking testbench for chebyshev_series_eval: streams samples and register writes,
// predicts every series sum in a scoreboard class and checks each result item in order.
// Depends on cse_pkg and the chebyshev_series_eval RTL.
`timescale 1ns / 1ps

module chebyshev_series_eval_test;
  import cse_pkg::*;

  // One predicted result item: the saturated series sum and its clip flag.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } series_result_t;

  // The scoreboard keeps its own copy of the configuration registers, works out the
  // series sum for every accepted sample and holds the sums in acceptance order.
  class series_scoreboard;
    logic signed [DATA_W-1:0]  range_low;
    logic        [SCALE_W-1:0] range_scale;
    logic signed [DATA_W-1:0]  coefs [NUM_COEFS];
    series_result_t            pending_sums [$];
    int                        mismatches;

    function new();
      range_low   = -32'sd65536;
      range_scale = 31'd65536;
      foreach (coefs[i]) coefs[i] = '0;
      mismatches  = 0;
    endfunction

    // Mirrors one register write; indexes past the coefficient bank change nothing.
    function void write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_RANGE_LOW) begin
        range_low = data;
      end else if (idx == REG_RANGE_SCALE) begin
        range_scale = data[SCALE_W-1:0];
      end else if (idx >= REG_COEF_FIRST && idx <= REG_COEF_LAST) begin
        coefs[idx - REG_COEF_FIRST] = data;
      end
    endfunction

    // Clamps to the signed 32-bit range and raises the flag when it had to.
    function longint clamp32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Maps x onto the interval, runs the three-term recurrence and sums the series.
    // Right shifts of signed longints round toward minus infinity, as the block does.
    function series_result_t eval_series(logic signed [DATA_W-1:0] x);
      series_result_t r;
      longint         one_q, d, u, t_prev, t_cur, t_next, acc, term;
      bit             hit;
      one_q = longint'(1) <<< FRAC_BITS;
      hit   = 1'b0;
      d     = longint'(x) - longint'(range_low);
      u     = ((d * longint'(range_scale)) >>> FRAC_BITS) - one_q;
      u     = clamp32(u, hit);
      acc    = longint'(coefs[0]);
      t_prev = one_q;
      t_cur  = u;
      for (int k = 1; k <= DEGREE && k < NUM_COEFS; k++) begin
        term = (longint'(coefs[k]) * t_cur) >>> FRAC_BITS;
        acc  = clamp32(acc + term, hit);
        // The step after the last used term is never formed, so it cannot clip.
        if (k < DEGREE) begin
          t_next = ((u * t_cur) >>> (FRAC_BITS - 1)) - t_prev;
          t_next = clamp32(t_next, hit);
          t_prev = t_cur;
          t_cur  = t_next;
        end
      end
      r.value = acc[DATA_W-1:0];
      r.sat   = hit;
      return r;
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] x);
      pending_sums.push_back(eval_series(x));
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic sat);
      series_result_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: result item with nothing pending, approx_value %h saturated %b",
                 $time, value, sat);
        return;
      end
      want = pending_sums.pop_front();
      if (value !== want.value) begin
        mismatches++;
        $display("%0t: approx_value mismatch, expected %h, actual %h",
                 $time, want.value, value);
      end
      if (sat !== want.sat) begin
        mismatches++;
        $display("%0t: saturated mismatch, expected %b, actual %b", $time, want.sat, sat);
      end
    endfunction
  endclass

  localparam int HOLD_CYCLES   = 80;      // receiver hold-off that fills the pipeline
  localparam int PHASES        = 8;       // random phases, each with its own settings
  localparam int PHASE_ITEMS   = 166;     // samples per random phase
  localparam int IDLE_PERCENT  = 11;

  logic                      clk;
  logic                      rst;
  logic                      sample_valid;
  logic                      sample_stall;
  logic signed [DATA_W-1:0]  sample;
  logic                      result_valid;
  logic                      result_stall;
  logic signed [DATA_W-1:0]  approx_value;
  logic                      saturated;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [INDEX_W-1:0]        cfg_index;
  logic [DATA_W-1:0]         cfg_data;

  series_scoreboard sb;

  // When steady is set neither side idles; hold_off asks the receiver for one long stall.
  bit steady;
  bit hold_off;

  // Register values for the next phase, indexed by register index.
  logic [DATA_W-1:0] cfg_plan [NUM_COEFS + 2];

  chebyshev_series_eval dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .approx_value (approx_value),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. A correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: stalls at random in about 11 percent of cycles, never while steady is set,
  // and once holds off for a long stretch so that every stage fills and the block
  // pushes back on its input. The stall changes only on falling edges.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Results are taken at the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      sb.check_result(approx_value, saturated);
    end
  end

  // Offers one sample, starting at a falling edge, and returns at the falling edge after
  // it was accepted. Valid stays high into the next call, so back-to-back items flow
  // without a bubble unless the sender decides to idle first.
  task automatic send_sample(input logic signed [DATA_W-1:0] x);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      sample_valid <= 1'b0;
      sample       <= $urandom;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= x;
    @(posedge clk);
    while (sample_stall !== 1'b0) @(posedge clk);
    sb.note_sample(x);
    @(negedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Loads every register from cfg_plan, then pokes one index past the register bank,
  // which the block must ignore.
  task automatic apply_cfg_plan();
    for (int i = REG_RANGE_LOW; i <= REG_COEF_LAST; i++) begin
      write_reg(i[INDEX_W-1:0], cfg_plan[i]);
    end
    write_reg(REG_COEF_LAST + 4'd1 + 4'($urandom_range(0, 7)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering samples and waits until every predicted sum has come back. Every
  // sample produces a result, so an empty queue means the pipeline is empty too.
  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int                       low_v;
    int                       width_q;
    bit                       wild;
    logic signed [DATA_W-1:0] x;

    sb           = new();
    steady       = 1'b0;
    hold_off     = 1'b0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero coefficients, interval [-1, 1]. The extreme samples still
    // push u so far out that the recurrence clips even though every term is zero.
    send_sample(32'sd0);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    drain();

    // A plain interval [-1, 1] with small coefficients: in-range samples, the interval
    // ends, and the extremes of the sample field.
    cfg_plan[REG_RANGE_LOW]      = 32'hFFFF_0000;
    cfg_plan[REG_RANGE_SCALE]    = 32'h0001_0000;
    cfg_plan[REG_COEF_FIRST]     = 32'h0000_8000;
    cfg_plan[REG_COEF_FIRST + 1] = 32'h0001_0000;
    cfg_plan[REG_COEF_FIRST + 2] = 32'hFFFF_8000;
    cfg_plan[REG_COEF_FIRST + 3] = 32'h0000_4000;
    cfg_plan[REG_COEF_FIRST + 4] = 32'hFFFF_E000;
    cfg_plan[REG_COEF_FIRST + 5] = 32'h0000_1000;
    apply_cfg_plan();
    send_sample(-32'sd65536);
    send_sample(32'sd65536);
    send_sample(32'sd0);
    send_sample(32'sh0000_8000);
    send_sample(-32'sh0000_3000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    drain();

    // Register extremes: the most negative low bound, the largest scale (written with
    // the unused top bit set) and coefficients at both ends of their range.
    cfg_plan[REG_RANGE_LOW]   = 32'h8000_0000;
    cfg_plan[REG_RANGE_SCALE] = 32'hFFFF_FFFF;
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_plan[REG_COEF_FIRST + i] = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    apply_cfg_plan();
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0001);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sd0);
    drain();

    // Zero scale: u is -1 for every sample. c0 - c1 overflows, so the running sum clips
    // high on the first term.
    cfg_plan[REG_RANGE_LOW]   = 32'h7FFF_FFFF;
    cfg_plan[REG_RANGE_SCALE] = 32'h0000_0000;
    for (int i = 0; i < NUM_COEFS; i++) cfg_plan[REG_COEF_FIRST + i] = 32'h0;
    cfg_plan[REG_COEF_FIRST]     = 32'h7FFF_FFFF;
    cfg_plan[REG_COEF_FIRST + 1] = 32'h8000_0000;
    apply_cfg_plan();
    send_sample(32'sh8000_0000);
    send_sample(32'sh1234_5678);
    send_sample(32'sh7FFF_FFFF);
    drain();

    // Random phases. Most use a sensible interval with scale = 2/(b-a) and samples
    // inside it, so u stays near [-1, 1] and the sums are meaningful; a tenth of those
    // samples fall anywhere. Every fourth phase randomizes everything, which mostly
    // saturates. Phase 1 runs with no idling at all, and phase 2 also holds the
    // receiver off long enough to back the pipeline up into the sender.
    for (int p = 0; p < PHASES; p++) begin
      wild    = (p % 4 == 3);
      width_q = $urandom_range(16384, 16 * 65536);
      low_v   = int'($urandom_range(0, 16 * 65536)) - 8 * 65536;
      if (wild) begin
        for (int i = REG_RANGE_LOW; i <= REG_COEF_LAST; i++) cfg_plan[i] = $urandom;
      end else begin
        cfg_plan[REG_RANGE_LOW]   = low_v;
        cfg_plan[REG_RANGE_SCALE] = 32'((64'd1 << 33) / width_q);
        for (int i = 0; i < NUM_COEFS; i++) begin
          cfg_plan[REG_COEF_FIRST + i] = int'($urandom_range(0, 262144)) - 131072;
        end
      end
      apply_cfg_plan();

      steady = (p == 1 || p == 2);
      if (p == 2) hold_off = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (wild || $urandom_range(9) == 0) begin
          x = $urandom;
        end else begin
          x = low_v + int'($urandom_range(0, width_q));
        end
        send_sample(x);
      end
      steady = 1'b0;
      drain();
    end

    // Everything has drained; keep clocking so that any stray output is still checked.
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
